@@ hw/rtl/hgrr_pkg.sv @@
// Package for the HTTP GET request recognizer: types, codes and match text.
`default_nettype none

package hgrr_pkg;

  // Receive buffer size; the configured byte limit is capped at this value.
  localparam int BUFFER_BYTES = 4096;

  localparam int LEN_WIDTH = 13;
  localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(BUFFER_BYTES);
  localparam logic [LEN_WIDTH-1:0] LEN_CAP   = LEN_WIDTH'(BUFFER_BYTES);
  localparam logic [LEN_WIDTH-1:0] COUNT_MAX = {LEN_WIDTH{1'b1}};

  localparam logic [3:0] URI_LEN = 4'd10;
  localparam logic [3:0] POS_MAX = 4'd15;
  localparam logic [1:0] METHOD_LAST = 2'd3;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_SP = 8'h20;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_URI     = 3'd2,
    PH_REST    = 3'd3,
    PH_HEADERS = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONTINUE  = 2'd0,
    ST_TERMINATE = 2'd1,
    ST_PROCEED   = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SVC_NONE = 2'd0,
    SVC_FAST = 2'd1,
    SVC_SLOW = 2'd2
  } service_t;

  // Running comparison of the URI against both accepted paths.
  typedef struct packed {
    logic [3:0] pos;
    logic       fast;
    logic       slow;
  } uri_match_t;

  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47; // G
      2'd1:    c = 8'h45; // E
      2'd2:    c = 8'h54; // T
      default: c = BYTE_SP;
    endcase
    return c;
  endfunction

  // "/test/fast" and "/test/slow" share their first six characters.
  function automatic logic [7:0] fast_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd5: c = 8'h2F; // /
      4'd1, 4'd4,
      4'd9:       c = 8'h74; // t
      4'd2:       c = 8'h65; // e
      4'd3, 4'd8: c = 8'h73; // s
      4'd6:       c = 8'h66; // f
      4'd7:       c = 8'h61; // a
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] slow_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd5: c = 8'h2F; // /
      4'd1, 4'd4: c = 8'h74; // t
      4'd2:       c = 8'h65; // e
      4'd3, 4'd6: c = 8'h73; // s
      4'd7:       c = 8'h6C; // l
      4'd8:       c = 8'h6F; // o
      4'd9:       c = 8'h77; // w
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  // Take one URI character into the comparison.
  function automatic uri_match_t uri_step(input uri_match_t m, input logic [7:0] b);
    uri_match_t r;
    r = m;
    if (m.pos < URI_LEN) begin
      if (b != fast_char(m.pos)) r.fast = 1'b0;
      if (b != slow_char(m.pos)) r.slow = 1'b0;
    end else begin
      r.fast = 1'b0;
      r.slow = 1'b0;
    end
    if (m.pos < POS_MAX) r.pos = m.pos + 4'd1;
    return r;
  endfunction

  function automatic service_t uri_verdict(input uri_match_t m);
    service_t s;
    if (m.pos == URI_LEN && m.fast) s = SVC_FAST;
    else if (m.pos == URI_LEN && m.slow) s = SVC_SLOW;
    else s = SVC_NONE;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/http_get_request_recognizer_core.sv @@
// HTTP GET request recognizer: byte parser with registered output and skid stage.
`default_nettype none

//  Channel   Signals                          Direction  Word
//  --------  -------------------------------  ---------  ------------------------------
//  input     in_valid, in_stall               in / out   request_byte[7:0], first
//  output    out_valid, out_stall             out / in   status[1:0], service[1:0]
//  config    cfg_valid, cfg_ready             in / out   max_request_len[12:0]
//
//  One byte is taken per cycle while in_stall is low; the parse update is a single pass
//  of logic between the parse state registers and the result register. Reset (rst,
//  synchronous) clears the parse state and sets the byte limit to 4096. A two-entry
//  output (result register plus skid register) lets a byte be accepted while a result
//  is stalled; in_stall rises only once both entries hold a word. The configuration
//  port is always ready; the user writes it only while the block is idle, unchecked.

module http_get_request_recognizer_core
  import hgrr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           request_byte,
  input  wire logic                 first,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [1:0]                service,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LEN_WIDTH-1:0] max_request_len
);

  // Configured limit and parse state.
  logic [LEN_WIDTH-1:0] max_len;
  phase_t               phase;
  logic [LEN_WIDTH-1:0] byte_count;
  uri_match_t           uri;
  logic                 pending_cr;
  logic                 line_just_ended;
  service_t             service_code;

  phase_t               phase_next;
  logic [LEN_WIDTH-1:0] byte_count_next;
  uri_match_t           uri_next;
  logic                 pending_cr_next;
  logic                 line_just_ended_next;
  service_t             service_code_next;

  status_t              res_status;
  service_t             res_service;
  logic [LEN_WIDTH-1:0] limit;

  // Skid register behind the result register.
  logic                 skid_valid;
  logic [1:0]           skid_status;
  logic [1:0]           skid_service;

  logic                 accept_in;
  logic                 take_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !in_stall;
  assign take_out  = out_valid && !out_stall;

  // Effective limit: capped at the buffer size, and never below one byte.
  always_comb begin
    if (max_len > LEN_CAP) limit = LEN_CAP;
    else if (max_len == '0) limit = LEN_WIDTH'(1);
    else limit = max_len;
  end

  // Parse update for the byte at the input. The state is first cleared when the
  // byte opens a new request, then the byte is applied to the current phase.
  always_comb begin
    logic do_uri;
    logic end_line;

    do_uri   = 1'b0;
    end_line = 1'b0;

    if (first) begin
      phase_next           = PH_METHOD;
      byte_count_next      = '0;
      uri_next             = '{pos: 4'd0, fast: 1'b1, slow: 1'b1};
      pending_cr_next      = 1'b0;
      line_just_ended_next = 1'b0;
      service_code_next    = SVC_NONE;
    end else begin
      phase_next           = phase;
      byte_count_next      = byte_count;
      uri_next             = uri;
      pending_cr_next      = pending_cr;
      line_just_ended_next = line_just_ended;
      service_code_next    = service_code;
    end

    res_status  = ST_CONTINUE;
    res_service = SVC_NONE;

    unique case (phase_next)
      PH_METHOD: begin
        if (request_byte == method_char(uri_next.pos[1:0])) begin
          if (uri_next.pos[1:0] == METHOD_LAST) begin
            phase_next   = PH_SKIP;
            uri_next.pos = 4'd0;
          end else begin
            uri_next.pos = uri_next.pos + 4'd1;
          end
        end else begin
          res_status = ST_TERMINATE;
        end
      end
      PH_SKIP: begin
        if (pending_cr_next || request_byte != BYTE_SP) begin
          phase_next = PH_URI;
          do_uri     = 1'b1;
        end
      end
      PH_URI: begin
        do_uri = 1'b1;
      end
      PH_REST: begin
        if (pending_cr_next && request_byte == BYTE_LF) end_line = 1'b1;
        else pending_cr_next = (request_byte == BYTE_CR);
      end
      PH_HEADERS: begin
        if (pending_cr_next && request_byte == BYTE_LF) begin
          pending_cr_next = 1'b0;
          if (line_just_ended_next) begin
            res_status  = ST_PROCEED;
            res_service = service_code_next;
          end else begin
            line_just_ended_next = 1'b1;
          end
        end else begin
          if (pending_cr_next) line_just_ended_next = 1'b0;
          if (request_byte == BYTE_CR) begin
            pending_cr_next = 1'b1;
          end else begin
            pending_cr_next      = 1'b0;
            line_just_ended_next = 1'b0;
          end
        end
      end
      PH_DONE: begin
        res_status = ST_IGNORED;
      end
      default: begin
        res_status = ST_IGNORED;
      end
    endcase

    // URI byte: a CR held back from the previous byte either closes the line
    // (with LF) or turns out to be an ordinary URI character.
    if (do_uri) begin
      if (pending_cr_next && request_byte == BYTE_LF) begin
        service_code_next = uri_verdict(uri_next);
        end_line          = 1'b1;
      end else begin
        if (pending_cr_next) begin
          pending_cr_next = 1'b0;
          uri_next        = uri_step(uri_next, BYTE_CR);
        end
        if (request_byte == BYTE_SP) begin
          service_code_next = uri_verdict(uri_next);
          phase_next        = PH_REST;
        end else if (request_byte == BYTE_CR) begin
          pending_cr_next = 1'b1;
        end else begin
          uri_next = uri_step(uri_next, request_byte);
        end
      end
    end

    // End of the request line: only a recognized URI lets the request go on.
    if (end_line) begin
      pending_cr_next = 1'b0;
      if (service_code_next == SVC_NONE) begin
        res_status = ST_TERMINATE;
      end else begin
        phase_next           = PH_HEADERS;
        line_just_ended_next = 1'b1;
      end
    end

    // Byte limit applies only to bytes that would otherwise continue.
    if (res_status == ST_CONTINUE) begin
      if (byte_count_next < COUNT_MAX) byte_count_next = byte_count_next + LEN_WIDTH'(1);
      if (byte_count_next >= limit) res_status = ST_TERMINATE;
    end
    if (res_status != ST_CONTINUE && res_status != ST_IGNORED) phase_next = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_request_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_METHOD;
      byte_count      <= '0;
      uri             <= '{pos: 4'd0, fast: 1'b1, slow: 1'b1};
      pending_cr      <= 1'b0;
      line_just_ended <= 1'b0;
      service_code    <= SVC_NONE;
    end else if (accept_in) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      uri             <= uri_next;
      pending_cr      <= pending_cr_next;
      line_just_ended <= line_just_ended_next;
      service_code    <= service_code_next;
    end
  end

  // Output control: the result register feeds the port, the skid register
  // catches a word that arrives while the result register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take_out) begin
        skid_valid <= 1'b0;
      end
    end else if (accept_in) begin
      if (out_valid && !take_out) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take_out) begin
        status  <= skid_status;
        service <= skid_service;
      end
    end else if (accept_in) begin
      if (out_valid && !take_out) begin
        skid_status  <= res_status;
        skid_service <= res_service;
      end else begin
        status  <= res_status;
        service <= res_service;
      end
    end
  end

  // The skid register is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the result register is empty");

  // A completed request always names the service it asked for.
  a_proceed_has_service: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_PROCEED) |-> (service == SVC_FAST || service == SVC_SLOW))
    else $error("proceed given without a recognized service");

  // Only a proceed word carries a service code.
  a_service_only_on_proceed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PROCEED) |-> (service == SVC_NONE))
    else $error("service code given on a word that is not proceed");

  // A held word stays in place until it is taken.
  a_skid_drains_in_order: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> (skid_valid && $stable(skid_status) && $stable(status)))
    else $error("stalled words changed before being taken");

endmodule

`default_nettype wire

@@ tb/hgrr_result_checker.sv @@
// Result checker for the HTTP GET request recognizer: predicts each output word and compares.
`timescale 1ns / 100ps

module hgrr_result_checker
  import hgrr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           request_byte,
  input  logic                 first,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           status,
  input  logic [1:0]           service,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [LEN_WIDTH-1:0] max_request_len,
  output int                   fail_count,
  output int                   pending_words
);

  localparam logic [31:0] METHOD_TEXT = "GET ";
  localparam logic [79:0] FAST_PATH   = "/test/fast";
  localparam logic [79:0] SLOW_PATH   = "/test/slow";

  typedef struct packed {
    status_t  st;
    service_t svc;
  } verdict_t;

  verdict_t verdict_q[$];
  verdict_t want;
  verdict_t got;
  int       mismatches = 0;
  int       waiting = 0;

  // Shadow copy of the parser state and of the byte limit register.
  phase_t               parse_ph;
  logic [LEN_WIDTH-1:0] req_bytes;
  logic [3:0]           uri_pos;
  logic                 fast_ok;
  logic                 slow_ok;
  logic                 cr_seen;
  logic                 blank_armed;
  service_t             svc_held;
  logic [LEN_WIDTH-1:0] len_limit;

  assign fail_count    = mismatches;
  assign pending_words = waiting;

  task restart_request();
    parse_ph    = PH_METHOD;
    req_bytes   = '0;
    uri_pos     = '0;
    fast_ok     = 1'b1;
    slow_ok     = 1'b1;
    cr_seen     = 1'b0;
    blank_armed = 1'b0;
    svc_held    = SVC_NONE;
  endtask

  task take_uri_char(input logic [7:0] b);
    if (uri_pos < URI_LEN) begin
      if (b != FAST_PATH[8*(9-int'(uri_pos)) +: 8]) fast_ok = 1'b0;
      if (b != SLOW_PATH[8*(9-int'(uri_pos)) +: 8]) slow_ok = 1'b0;
    end else begin
      fast_ok = 1'b0;
      slow_ok = 1'b0;
    end
    if (uri_pos < POS_MAX) uri_pos = uri_pos + 4'd1;
  endtask

  task close_uri();
    if (uri_pos == URI_LEN && fast_ok) svc_held = SVC_FAST;
    else if (uri_pos == URI_LEN && slow_ok) svc_held = SVC_SLOW;
    else svc_held = SVC_NONE;
  endtask

  task close_request_line(output status_t st);
    cr_seen = 1'b0;
    if (svc_held == SVC_NONE) begin
      st = ST_TERMINATE;
    end else begin
      parse_ph    = PH_HEADERS;
      blank_armed = 1'b1;
      st          = ST_CONTINUE;
    end
  endtask

  task uri_byte(input logic [7:0] b, output status_t st);
    st = ST_CONTINUE;
    if (cr_seen && b == BYTE_LF) begin
      close_uri();
      close_request_line(st);
    end else begin
      // A CR that was not followed by LF becomes part of the URI.
      if (cr_seen) begin
        cr_seen = 1'b0;
        take_uri_char(BYTE_CR);
      end
      if (b == BYTE_SP) begin
        close_uri();
        parse_ph = PH_REST;
      end else if (b == BYTE_CR) begin
        cr_seen = 1'b1;
      end else begin
        take_uri_char(b);
      end
    end
  endtask

  task predict_verdict(input logic [7:0] b, input logic lead, output verdict_t v);
    logic [LEN_WIDTH-1:0] lim;
    status_t              st;
    st    = ST_CONTINUE;
    v.svc = SVC_NONE;
    if (lead) restart_request();
    if (parse_ph == PH_DONE) begin
      st = ST_IGNORED;
    end else begin
      case (parse_ph)
        PH_METHOD: begin
          if (uri_pos < 4'd4 && b == METHOD_TEXT[8*(3-int'(uri_pos)) +: 8]) begin
            uri_pos = uri_pos + 4'd1;
            if (uri_pos == 4'd4) begin
              parse_ph = PH_SKIP;
              uri_pos  = '0;
            end
          end else begin
            st = ST_TERMINATE;
          end
        end
        PH_SKIP: begin
          if (cr_seen || b != BYTE_SP) begin
            parse_ph = PH_URI;
            uri_byte(b, st);
          end
        end
        PH_URI: uri_byte(b, st);
        PH_REST: begin
          if (cr_seen && b == BYTE_LF) close_request_line(st);
          else cr_seen = (b == BYTE_CR);
        end
        default: begin
          if (cr_seen && b == BYTE_LF) begin
            cr_seen = 1'b0;
            if (blank_armed) begin
              st    = ST_PROCEED;
              v.svc = svc_held;
            end else begin
              blank_armed = 1'b1;
            end
          end else begin
            if (cr_seen) blank_armed = 1'b0;
            if (b == BYTE_CR) begin
              cr_seen = 1'b1;
            end else begin
              cr_seen     = 1'b0;
              blank_armed = 1'b0;
            end
          end
        end
      endcase
      if (st == ST_CONTINUE) begin
        lim = len_limit;
        if (lim > LEN_CAP) lim = LEN_CAP;
        if (lim == '0) lim = LEN_WIDTH'(1);
        if (req_bytes < COUNT_MAX) req_bytes = req_bytes + LEN_WIDTH'(1);
        if (req_bytes >= lim) st = ST_TERMINATE;
      end
      if (st != ST_CONTINUE) parse_ph = PH_DONE;
    end
    v.st = st;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      len_limit = LEN_RESET;
      restart_request();
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: word with no prediction: expected none, got status %0d service %0d",
                   $time, status, service);
        end else begin
          want = verdict_q.pop_front();
          got  = '{st: status_t'(status), svc: service_t'(service)};
          if (got.st !== want.st) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.st, status);
          end
          if (got.svc !== want.svc) begin
            mismatches++;
            $display("%0t: service mismatch: expected %0d, got %0d", $time, want.svc, service);
          end
        end
      end
      // A byte taken at the same edge as a limit write still sees the old limit.
      if (in_valid && !in_stall) begin
        predict_verdict(request_byte, first, want);
        verdict_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) len_limit = max_request_len;
    end
    waiting = verdict_q.size();
  end

endmodule

@@ tb/tb_http_get_request_recognizer_core.sv @@
// Testbench top for the HTTP GET request recognizer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_http_get_request_recognizer_core;
  import hgrr_pkg::*;

  // Length of the single long receiver hold, so that the output stage fills
  // and the block has to stall its input while the sender keeps offering words.
  localparam int LONG_HOLD = 200;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           request_byte;
  logic                 first;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic [1:0]           service;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LEN_WIDTH-1:0] max_request_len;

  int fail_count;
  int pending_words;

  // Flow control knobs. The receiver knobs are changed with nonblocking
  // assignments so that the receiver process, which also runs on the falling
  // edge, always sees a value that is settled for that step.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int words_sent = 0;

  // Bytes of the request that is being assembled.
  logic [7:0] byte_q[$];

  http_get_request_recognizer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .request_byte   (request_byte),
    .first          (first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .service        (service),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .max_request_len(max_request_len)
  );

  hgrr_result_checker results_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .request_byte   (request_byte),
    .first          (first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .service        (service),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .max_request_len(max_request_len),
    .fail_count     (fail_count),
    .pending_words  (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous limit on the whole run; the slowest correct run is far shorter.
  initial begin
    #6_000_000;
    $display("tb_http_get_request_recognizer_core NOT OK");
    $finish;
  end

  // Receiver side. Each falling edge it decides whether to stall the next
  // word; when a long hold has been asked for, it stalls for the LONG_HOLD
  // length counted here and then returns to random stalls.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one word on the input channel and return at the falling edge after
  // it has been accepted. The valid stays high, so back-to-back words follow
  // without a gap; a random gap lowers it first. The stall only changes at a
  // rising edge, so its value at the falling edge decides the next edge.
  task send_byte(input logic [7:0] b, input logic lead);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     = 1'b1;
    request_byte = b;
    first        = lead;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Send the assembled request, with first set on its opening byte only.
  task send_queue();
    for (int i = 0; i < byte_q.size(); i++) send_byte(byte_q[i], i == 0);
    byte_q.delete();
  endtask

  // Stop offering words and wait until every predicted word has come back.
  // Each byte gives one predicted word, which the checker counts until it is taken.
  task drain();
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task write_limit(input logic [LEN_WIDTH-1:0] value);
    max_request_len = value;
    cfg_valid       = 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task push_crlf();
    byte_q.push_back(BYTE_CR);
    byte_q.push_back(BYTE_LF);
  endtask

  // Zero to three header lines. Their characters include stray CRs and LFs,
  // so the blank-line detection sees broken line ends as well as clean ones.
  task push_headers();
    int pick;
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(9);
        if (pick == 0) byte_q.push_back(BYTE_CR);
        else if (pick == 1) byte_q.push_back(BYTE_LF);
        else byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      push_crlf();
    end
  endtask

  // Build and send one random request. Most are well formed with random
  // content, so the parse reaches the header lines and the blank line; the
  // rest have a bad URI, a bad method, or are plain noise.
  task send_random_request();
    int         kind;
    int         k;
    string      path;
    string      meth;
    logic [7:0] c;
    kind = $urandom_range(99);
    path = $urandom_range(1) ? "/test/fast" : "/test/slow";
    meth = "GET ";
    if (kind < 55) begin
      push_text(meth);
      repeat ($urandom_range(0, 3)) byte_q.push_back(BYTE_SP);
      push_text(path);
      if ($urandom_range(1)) push_text(" HTTP/1.1");
      push_crlf();
      push_headers();
      push_crlf();
      send_queue();
    end else if (kind < 75) begin
      push_text(meth);
      repeat ($urandom_range(0, 3)) byte_q.push_back(BYTE_SP);
      k = $urandom_range(9);
      case ($urandom_range(4))
        // Empty or all-space URI: nothing is added here.
        0: ;
        1: for (int i = 0; i < k; i++) byte_q.push_back(path[i]);
        2: begin
          push_text(path);
          byte_q.push_back(8'($urandom_range(33, 126)));
        end
        3: begin
          for (int i = 0; i < 10; i++) begin
            c = (i == k) ? 8'($urandom_range(255)) : path[i];
            byte_q.push_back(c);
          end
        end
        default: begin
          // A lone CR inside the URI spoils the match.
          for (int i = 0; i < 10; i++) begin
            if (i == k) byte_q.push_back(BYTE_CR);
            byte_q.push_back(path[i]);
          end
        end
      endcase
      if ($urandom_range(1)) push_text(" x");
      push_crlf();
      push_headers();
      push_crlf();
      send_queue();
    end else if (kind < 85) begin
      k = $urandom_range(3);
      for (int i = 0; i < 4; i++) begin
        if (i != k) c = meth[i];
        else if ($urandom_range(2) == 0) c = BYTE_CR;
        else if ($urandom_range(1) == 0) c = BYTE_LF;
        else c = 8'($urandom_range(255));
        byte_q.push_back(c);
      end
      push_text(path);
      push_crlf();
      push_crlf();
      send_queue();
    end else begin
      // Noise: any byte value with a random first flag on each word.
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    // Trailing bytes without first are mostly ignored after a final status.
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // One phase of the random part: wait for the block to go idle, set the
  // byte limit and the idle rates, then send requests until enough words
  // have gone in.
  task run_phase(input logic [LEN_WIDTH-1:0] limit, input int send_pct, input int recv_pct,
                 input int quota, input bit with_hold);
    int start;
    drain();
    write_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (with_hold) hold_requests <= hold_requests + 1;
    start = words_sent;
    while (words_sent - start < quota) send_random_request();
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    request_byte    = '0;
    first           = 1'b0;
    cfg_valid       = 1'b0;
    max_request_len = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The block is idle after reset, so the limit can be
    // written at once.
    write_limit(LEN_RESET);
    // Bytes before any first byte open a request; 0xFF is a wrong method
    // byte, and the 0x00 after it is ignored.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // A CR before the method is confirmed terminates; the LF is ignored.
    push_text("G");
    push_crlf();
    send_queue();
    // With a limit of 18 the shortest fast request completes on its very
    // last byte, where proceed has to win over the limit.
    drain();
    write_limit(LEN_WIDTH'(18));
    push_text("GET /test/fast");
    push_crlf();
    push_crlf();
    send_queue();
    // An all-space URI terminates at the LF of the request line.
    push_text("GET  ");
    push_crlf();
    send_queue();

    // Random part. Receiver idles more than the sender first, then the other
    // way round, then neither side idles. A limit above the buffer size acts
    // as the buffer size.
    run_phase(13'h1FFF, 34, 52, 100, 1'b0);
    // A limit of zero acts as one.
    run_phase('0, 34, 52, 60, 1'b0);
    run_phase(LEN_WIDTH'($urandom_range(10, 60)), 34, 52, 180, 1'b0);
    run_phase(LEN_WIDTH'(1), 52, 34, 40, 1'b0);
    // The long receiver hold falls at the start of this phase.
    run_phase(LEN_RESET, 52, 34, 280, 1'b1);
    run_phase(LEN_WIDTH'($urandom_range(10, 60)), 0, 0, 130, 1'b0);
    run_phase(LEN_WIDTH'(4095), 0, 0, 160, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_http_get_request_recognizer_core OK");
    end else begin
      $display("tb_http_get_request_recognizer_core NOT OK");
    end
    $finish;
  end

endmodule
